### design/spq_pkg.sv
// Shared constants and types for the sorted minimum priority queue.
`default_nettype none
package spq_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int PRIO_BITS_DEF = 16;

  localparam int XY_BITS     = 10;
  localparam int IN_PRIO_W   = 16;
  localparam int OUT_XY_BITS = 11;
  localparam int OCC_BITS    = 7;

  localparam int IN_DATA_W   = 40;  // x, y, prio packed and padded to bytes
  localparam int OUT_DATA_W  = 48;  // out_x, out_y, out_prio, occupancy padded
  localparam int OUT_USER_W  = 2;   // was_empty, dropped
  localparam int RESULT_W    = OUT_DATA_W + OUT_USER_W;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef struct packed {
    logic push_go;
    logic pop_go;
  } op_t;

endpackage
`default_nettype wire

### design/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none
module spq_cell
  import spq_pkg::*;
#(
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int CNT_W     = 7,
  parameter int IDX       = 0
) (
  input  wire logic                 clk,
  input  wire op_t                  op,
  input  wire logic [CNT_W-1:0]     count,
  input  wire logic [XY_BITS-1:0]   new_x,
  input  wire logic [XY_BITS-1:0]   new_y,
  input  wire logic [PRIO_BITS-1:0] new_prio,
  input  wire logic                 left_ge,
  input  wire logic [XY_BITS-1:0]   left_x,
  input  wire logic [XY_BITS-1:0]   left_y,
  input  wire logic [PRIO_BITS-1:0] left_prio,
  input  wire logic [XY_BITS-1:0]   right_x,
  input  wire logic [XY_BITS-1:0]   right_y,
  input  wire logic [PRIO_BITS-1:0] right_prio,
  output logic                      ge,
  output logic [XY_BITS-1:0]        x,
  output logic [XY_BITS-1:0]        y,
  output logic [PRIO_BITS-1:0]      prio
);

  logic held;

  // The new entry belongs at or before this slot when the slot is empty
  // or holds an equal or larger priority.
  assign held = CNT_W'(IDX) < count;
  assign ge   = !held || (prio >= new_prio);

  always_ff @(posedge clk) begin
    if (op.push_go && left_ge) begin
      x    <= left_x;
      y    <= left_y;
      prio <= left_prio;
    end else if (op.push_go && ge) begin
      x    <= new_x;
      y    <= new_y;
      prio <= new_prio;
    end else if (op.pop_go) begin
      x    <= right_x;
      y    <= right_y;
      prio <= right_prio;
    end
  end

endmodule
`default_nettype wire

### design/spq_obuf.sv
// Two-deep output buffer: result register plus skid register.
`default_nettype none
module spq_obuf
  import spq_pkg::*;
#(
  parameter int W = RESULT_W
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         take;

  assign in_ready = !skid_valid;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_data  <= in_data;
          out_valid <= take;
        end
      end else if (take) begin
        // park the transfer until the downstream side drains
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid holds data with empty output");

endmodule
`default_nettype wire

### design/sorted_min_priority_queue_core.sv
// Sorted minimum priority queue: a chain of entry cells with a buffered result.
// The result of each accepted transfer is registered in the output buffer before it appears on the master side.
// Throughput: one push or pop per cycle while the output buffer has room; all cells compare and shift in parallel.
// The two-deep output buffer keeps input ready for one more transfer while a result waits.
// Reset clears the entry count and the output buffer; cell contents are not reset.
`default_nettype none
module sorted_min_priority_queue_core
  import spq_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // pos_x[9:0], pos_y[19:10], prio[35:20]
  input  wire logic [0:0]            s_axis_tuser,  // kind[0]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // out_x[10:0], out_y[21:11],
                                                    // out_prio[37:22], occupancy[44:38]
  output logic [OUT_USER_W-1:0]      m_axis_tuser   // was_empty[0], dropped[1]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 accept;
  logic                 is_push;
  logic                 full;
  logic                 empty;
  op_t                  op;
  logic [XY_BITS-1:0]   in_x;
  logic [XY_BITS-1:0]   in_y;
  logic [PRIO_BITS-1:0] in_prio;

  logic [XY_BITS-1:0]   cx [CAPACITY];
  logic [XY_BITS-1:0]   cy [CAPACITY];
  logic [PRIO_BITS-1:0] cp [CAPACITY];
  logic                 cge [CAPACITY];

  logic [OUT_XY_BITS-1:0] res_x;
  logic [OUT_XY_BITS-1:0] res_y;
  logic [IN_PRIO_W-1:0]   res_prio;
  logic                   res_empty;
  logic                   res_drop;
  logic [RESULT_W-1:0]    res;
  logic [RESULT_W-1:0]    buf_data;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign is_push = s_axis_tuser[0] == KIND_PUSH;
  assign in_x    = s_axis_tdata[9:0];
  assign in_y    = s_axis_tdata[19:10];
  assign in_prio = PRIO_BITS'(s_axis_tdata[35:20]);
  assign full    = count == CNT_W'(CAPACITY);
  assign empty   = count == '0;

  assign op.push_go = accept && is_push && !full;
  assign op.pop_go  = accept && !is_push && !empty;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 l_ge;
      logic [XY_BITS-1:0]   l_x, l_y, r_x, r_y;
      logic [PRIO_BITS-1:0] l_p, r_p;
      if (i == 0) begin : g_head
        assign l_ge = 1'b0;
        assign l_x  = '0;
        assign l_y  = '0;
        assign l_p  = '0;
      end else begin : g_mid
        assign l_ge = cge[i-1];
        assign l_x  = cx[i-1];
        assign l_y  = cy[i-1];
        assign l_p  = cp[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign r_x = '0;
        assign r_y = '0;
        assign r_p = '0;
      end else begin : g_body
        assign r_x = cx[i+1];
        assign r_y = cy[i+1];
        assign r_p = cp[i+1];
      end
      spq_cell #(
        .PRIO_BITS(PRIO_BITS),
        .CNT_W    (CNT_W),
        .IDX      (i)
      ) u_cell (
        .clk       (clk),
        .op        (op),
        .count     (count),
        .new_x     (in_x),
        .new_y     (in_y),
        .new_prio  (in_prio),
        .left_ge   (l_ge),
        .left_x    (l_x),
        .left_y    (l_y),
        .left_prio (l_p),
        .right_x   (r_x),
        .right_y   (r_y),
        .right_prio(r_p),
        .ge        (cge[i]),
        .x         (cx[i]),
        .y         (cy[i]),
        .prio      (cp[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (op.push_go) begin
      count_next = count + CNT_W'(1);
    end else if (op.pop_go) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    res_x     = '0;
    res_y     = '0;
    res_prio  = '0;
    res_empty = 1'b0;
    res_drop  = 1'b0;
    if (is_push) begin
      res_drop = full;
    end else if (empty) begin
      res_x     = '1;
      res_y     = '1;
      res_empty = 1'b1;
    end else begin
      res_x    = {1'b0, cx[0]};
      res_y    = {1'b0, cy[0]};
      res_prio = IN_PRIO_W'(cp[0]);
    end
    res = {res_drop, res_empty, 3'b000, OCC_BITS'(count_next), res_prio, res_y, res_x};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  spq_obuf #(
    .W(RESULT_W)
  ) u_obuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (res),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (buf_data)
  );

  assign m_axis_tdata = buf_data[OUT_DATA_W-1:0];
  assign m_axis_tuser = buf_data[RESULT_W-1:OUT_DATA_W];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY)) else $error("entry count beyond capacity");

  a_empty_pop_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && !is_push && empty |=> count == '0)
    else $error("pop on empty queue changed the count");

  a_full_push_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && is_push && full |=> count == CNT_W'(CAPACITY))
    else $error("push on full queue changed the count");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(2) |-> cp[0] <= cp[1]) else $error("front entries out of order");

endmodule
`default_nettype wire

### bench/sorted_min_priority_queue_core_test.sv
// Self-checking stream testbench for the sorted minimum priority queue core.
`timescale 1ns / 1ps
module sorted_min_priority_queue_core_test;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DIRECTED_N   = 19;
  localparam int DRAIN_CYCLES = 8;
  localparam logic signed [OUT_XY_BITS-1:0] EMPTY_POS = -11'sd1;
  localparam logic [IN_PRIO_W-1:0] PRIO_KEEP = IN_PRIO_W'((1 << PRIO_BITS_DEF) - 1);

  typedef struct packed {
    logic [XY_BITS-1:0]   x;
    logic [XY_BITS-1:0]   y;
    logic [IN_PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic signed [OUT_XY_BITS-1:0] ox;
    logic signed [OUT_XY_BITS-1:0] oy;
    logic [IN_PRIO_W-1:0]          prio;
    logic                          was_empty;
    logic                          dropped;
    logic [OCC_BITS-1:0]           occ;
  } op_result_t;

  typedef struct packed {
    logic                 kind;
    logic [XY_BITS-1:0]   x;
    logic [XY_BITS-1:0]   y;
    logic [IN_PRIO_W-1:0] prio;
    logic                 typed;
    op_result_t           want;
  } stim_row_t;

  localparam op_result_t UNTYPED = '0;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  // shadow copy of the sorted queue, slot 0 at the front
  entry_t     held [CAPACITY_DEF];
  int         held_count = 0;
  op_result_t pending_results [$];
  int         err_count = 0;
  int         burst_left = 1;
  int         idle_cycles = 0;
  int         stall_mode = 0;
  int         mode_left = 0;

  stim_row_t directed_rows [DIRECTED_N] = '{
    '{KIND_POP,  10'd0,    10'd0,    16'd0,     1'b1, '{EMPTY_POS, EMPTY_POS, 16'd0, 1'b1, 1'b0, 7'd0}},
    '{KIND_PUSH, 10'd0,    10'd0,    16'd0,     1'b1, '{11'sd0, 11'sd0, 16'd0, 1'b0, 1'b0, 7'd1}},
    '{KIND_PUSH, 10'd1023, 10'd1023, 16'hFFFF,  1'b1, '{11'sd0, 11'sd0, 16'd0, 1'b0, 1'b0, 7'd2}},
    '{KIND_PUSH, 10'd1023, 10'd0,    16'd0,     1'b1, '{11'sd0, 11'sd0, 16'd0, 1'b0, 1'b0, 7'd3}},
    '{KIND_PUSH, 10'd0,    10'd1023, 16'hFFFF,  1'b1, '{11'sd0, 11'sd0, 16'd0, 1'b0, 1'b0, 7'd4}},
    '{KIND_PUSH, 10'd512,  10'd256,  16'h8000,  1'b1, '{11'sd0, 11'sd0, 16'd0, 1'b0, 1'b0, 7'd5}},
    '{KIND_PUSH, 10'd341,  10'd682,  16'h5555,  1'b1, '{11'sd0, 11'sd0, 16'd0, 1'b0, 1'b0, 7'd6}},
    '{KIND_PUSH, 10'd682,  10'd341,  16'hAAAA,  1'b1, '{11'sd0, 11'sd0, 16'd0, 1'b0, 1'b0, 7'd7}},
    // equal priorities leave newest first
    '{KIND_POP,  10'd0,    10'd0,    16'd0,     1'b0, UNTYPED},
    '{KIND_POP,  10'd1023, 10'd1023, 16'hFFFF,  1'b0, UNTYPED},
    '{KIND_POP,  10'd0,    10'd0,    16'd0,     1'b0, UNTYPED},
    '{KIND_POP,  10'd682,  10'd341,  16'hAAAA,  1'b0, UNTYPED},
    '{KIND_POP,  10'd0,    10'd0,    16'd0,     1'b0, UNTYPED},
    '{KIND_POP,  10'd0,    10'd0,    16'd0,     1'b0, UNTYPED},
    '{KIND_POP,  10'd0,    10'd0,    16'd0,     1'b0, UNTYPED},
    '{KIND_POP,  10'd0,    10'd0,    16'd0,     1'b1, '{EMPTY_POS, EMPTY_POS, 16'd0, 1'b1, 1'b0, 7'd0}},
    '{KIND_PUSH, 10'd5,    10'd6,    16'd7,     1'b1, '{11'sd0, 11'sd0, 16'd0, 1'b0, 1'b0, 7'd1}},
    '{KIND_POP,  10'd0,    10'd0,    16'd0,     1'b1, '{11'sd5, 11'sd6, 16'd7, 1'b0, 1'b0, 7'd0}},
    '{KIND_POP,  10'd1023, 10'd1023, 16'hFFFF,  1'b1, '{EMPTY_POS, EMPTY_POS, 16'd0, 1'b1, 1'b0, 7'd0}}
  };

  sorted_min_priority_queue_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one push or pop to the shadow queue and return the result it should produce.
  function automatic op_result_t apply_queue_op(logic kind, logic [XY_BITS-1:0] x,
                                                logic [XY_BITS-1:0] y,
                                                logic [IN_PRIO_W-1:0] prio);
    op_result_t r;
    int slot;
    r = '0;
    if (kind == KIND_PUSH) begin
      if (held_count >= CAPACITY_DEF) begin
        r.dropped = 1'b1;
      end else begin
        slot = held_count;
        while (slot > 0 && held[slot-1].prio >= (prio & PRIO_KEEP)) begin
          held[slot] = held[slot-1];
          slot--;
        end
        held[slot] = '{x, y, prio & PRIO_KEEP};
        held_count++;
      end
    end else if (held_count == 0) begin
      r.ox        = EMPTY_POS;
      r.oy        = EMPTY_POS;
      r.was_empty = 1'b1;
    end else begin
      r.ox   = {1'b0, held[0].x};
      r.oy   = {1'b0, held[0].y};
      r.prio = held[0].prio;
      for (int i = 0; i < held_count - 1; i++) held[i] = held[i+1];
      held_count--;
    end
    r.occ = OCC_BITS'(held_count);
    return r;
  endfunction

  // Drive one operation, wait for its transfer, record the result it should give, and idle between bursts.
  task automatic send_op(input logic kind, input logic [XY_BITS-1:0] x,
                         input logic [XY_BITS-1:0] y, input logic [IN_PRIO_W-1:0] prio,
                         input logic typed, input op_result_t want);
    op_result_t predicted;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - 2*XY_BITS - IN_PRIO_W){1'b0}}, prio, y, x};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    predicted = apply_queue_op(kind, x, y, prio);
    pending_results.push_back(typed ? want : predicted);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the input side until every outstanding result has arrived.
  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Result side: check each transfer, then pick the next ready value.
  always @(posedge clk) begin
    op_result_t got;
    op_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.ox        = m_axis_tdata[10:0];
      got.oy        = m_axis_tdata[21:11];
      got.prio      = m_axis_tdata[37:22];
      got.occ       = m_axis_tdata[44:38];
      got.was_empty = m_axis_tuser[0];
      got.dropped   = m_axis_tuser[1];
      if (pending_results.size() == 0) begin
        $error("result transfer with no operation outstanding");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.ox !== want.ox) begin
          $error("out_x: expected %0d, got %0d", want.ox, got.ox);
          err_count++;
        end
        if (got.oy !== want.oy) begin
          $error("out_y: expected %0d, got %0d", want.oy, got.oy);
          err_count++;
        end
        if (got.prio !== want.prio) begin
          $error("out_prio: expected %0d, got %0d", want.prio, got.prio);
          err_count++;
        end
        if (got.was_empty !== want.was_empty) begin
          $error("was_empty: expected %0d, got %0d", want.was_empty, got.was_empty);
          err_count++;
        end
        if (got.dropped !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
          err_count++;
        end
        if (got.occ !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, got.occ);
          err_count++;
        end
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(3);
      mode_left  = $urandom_range(20, 150);
    end
    mode_left--;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(3) != 0);
      2: m_axis_tready <= ($urandom_range(3) == 0);
      default: m_axis_tready <= (mode_left % 5 == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int sent;
    int phase;
    int phase_len;
    int push_pct;
    int prio_mode;
    logic kind;
    logic [IN_PRIO_W-1:0] prio;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_op(directed_rows[i].kind, directed_rows[i].x, directed_rows[i].y,
              directed_rows[i].prio, directed_rows[i].typed, directed_rows[i].want);
    wait_drained();

    // fill past capacity first, then drain past empty, then mixed phases
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          push_pct  = 100;
          phase_len = 80;
        end
        1: begin
          push_pct  = 0;
          phase_len = 80;
        end
        default: begin
          case ($urandom_range(3))
            0: push_pct = 90;
            1: push_pct = 60;
            2: push_pct = 40;
            default: push_pct = 10;
          endcase
          phase_len = $urandom_range(20, 120);
        end
      endcase
      prio_mode = $urandom_range(2);
      if (phase == 10) wait_drained();
      repeat (phase_len) begin
        kind = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
        case (prio_mode)
          0: prio = IN_PRIO_W'($urandom_range(16'hFFFF));
          1: prio = IN_PRIO_W'($urandom_range(7));  // many ties
          default: begin
            case ($urandom_range(2))
              0: prio = '0;
              1: prio = '1;
              default: prio = IN_PRIO_W'($urandom_range(16'hFFFF));
            endcase
          end
        endcase
        send_op(kind, XY_BITS'($urandom_range(1023)), XY_BITS'($urandom_range(1023)), prio,
                1'b0, UNTYPED);
        sent++;
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
design/spq_pkg.sv
design/spq_cell.sv
design/spq_obuf.sv
design/sorted_min_priority_queue_core.sv
bench/sorted_min_priority_queue_core_test.sv
